FILE: rtl/core/vcp_pkg.sv
// ----------------------------------------------------------------------------
// vcp_pkg
// Shared types, codes and character classes of the version constraint parser.
// ----------------------------------------------------------------------------
`default_nettype none

package vcp_pkg;

  localparam int PRE_SIZE_DEF = 32;
  localparam int NUM_W        = 30;
  localparam int LEN_W        = 8;
  localparam int Q_DEPTH      = 2;
  localparam int ACC_W        = NUM_W + 4;

  localparam logic [ACC_W-1:0] NUM_LIMIT = ACC_W'(999999999);

  typedef enum logic [3:0] {
    PH_WS,
    PH_STAR,
    PH_GT,
    PH_MAJOR,
    PH_MINOR,
    PH_PATCH,
    PH_PRE,
    PH_ERR
  } ph_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SUM,
    BS_CHR
  } bs_t;

  typedef logic [2:0] kind_t;

  localparam kind_t K_WILD  = 3'd0;
  localparam kind_t K_EXACT = 3'd1;
  localparam kind_t K_GTE   = 3'd2;
  localparam kind_t K_LT    = 3'd3;
  localparam kind_t K_CARET = 3'd4;
  localparam kind_t K_TILDE = 3'd5;

  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic             ok;
    kind_t            kind;
    logic [NUM_W-1:0] major;
    logic [NUM_W-1:0] minor;
    logic [NUM_W-1:0] patch;
    logic [LEN_W-1:0] len;
  } run_rec_t;

  typedef struct packed {
    logic     push;
    run_rec_t rec;
  } run_push_t;

  function automatic logic is_ws(input logic [7:0] c);
    return c inside {8'd32, [8'd9:8'd13]};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_pre_char(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a], CH_DOT, CH_DASH};
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/vcp_ram.sv
// ----------------------------------------------------------------------------
// vcp_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: rtl/core/vcp_front.sv
// ----------------------------------------------------------------------------
// vcp_front
// Character parser: classifies each character, accumulates the numbers,
// stores prerelease characters and pushes one run summary at end of text.
// ----------------------------------------------------------------------------
`default_nettype none

module vcp_front #(
  parameter int PRE_SIZE = vcp_pkg::PRE_SIZE_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [7:0]                  in_char_code,
  input  wire logic                        in_end_of_text,
  input  wire logic                        q_full,
  input  wire logic                        ram_busy,
  output vcp_pkg::run_push_t               push,
  output logic                             ram_we,
  output logic [$clog2(PRE_SIZE)-1:0]      ram_waddr,
  output logic [7:0]                       ram_wdata
);

  localparam int PCW = $clog2(PRE_SIZE);
  localparam logic [PCW-1:0] CNT_MAX = PCW'(PRE_SIZE - 1);

  vcp_pkg::ph_t             phase_r, phase_nxt;
  vcp_pkg::kind_t           kind_r, kind_nxt;
  logic [vcp_pkg::NUM_W-1:0] acc_r, acc_nxt;
  logic                     seen_r, seen_nxt;
  logic [vcp_pkg::NUM_W-1:0] major_r, major_nxt;
  logic [vcp_pkg::NUM_W-1:0] minor_r, minor_nxt;
  logic [PCW-1:0]           cnt_r, cnt_nxt;

  logic                     accept;
  logic [7:0]               dval;
  logic [vcp_pkg::ACC_W-1:0] acc_ext;
  logic [vcp_pkg::ACC_W-1:0] acc_mul;
  logic                     ok;

  assign in_ready  = !q_full && !(phase_r == vcp_pkg::PH_PRE && ram_busy);
  assign accept    = in_valid && in_ready;
  assign dval      = in_char_code - vcp_pkg::CH_ZERO;
  assign acc_ext   = vcp_pkg::ACC_W'(acc_r);
  assign acc_mul   = (acc_ext << 3) + (acc_ext << 1) + vcp_pkg::ACC_W'(dval[3:0]);
  assign ram_waddr = cnt_r;
  assign ram_wdata = in_char_code;

  always_comb begin
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    major_nxt = major_r;
    minor_nxt = minor_r;
    cnt_nxt   = cnt_r;
    ram_we    = 1'b0;
    ok        = 1'b0;
    push      = '0;

    if (accept) begin
      case (phase_r)
        vcp_pkg::PH_WS: begin
          if (vcp_pkg::is_ws(in_char_code)) begin
            phase_nxt = vcp_pkg::PH_WS;
          end else if (in_char_code == vcp_pkg::CH_STAR) begin
            kind_nxt  = vcp_pkg::K_WILD;
            phase_nxt = vcp_pkg::PH_STAR;
          end else if (in_char_code == vcp_pkg::CH_CARET) begin
            kind_nxt  = vcp_pkg::K_CARET;
            phase_nxt = vcp_pkg::PH_MAJOR;
          end else if (in_char_code == vcp_pkg::CH_TILDE) begin
            kind_nxt  = vcp_pkg::K_TILDE;
            phase_nxt = vcp_pkg::PH_MAJOR;
          end else if (in_char_code == vcp_pkg::CH_GT) begin
            kind_nxt  = vcp_pkg::K_EXACT;
            phase_nxt = vcp_pkg::PH_GT;
          end else if (in_char_code == vcp_pkg::CH_LT) begin
            kind_nxt  = vcp_pkg::K_LT;
            phase_nxt = vcp_pkg::PH_MAJOR;
          end else if (vcp_pkg::is_digit(in_char_code)) begin
            kind_nxt  = vcp_pkg::K_EXACT;
            acc_nxt   = vcp_pkg::NUM_W'(dval[3:0]);
            seen_nxt  = 1'b1;
            phase_nxt = vcp_pkg::PH_MAJOR;
          end else begin
            kind_nxt  = vcp_pkg::K_EXACT;
            phase_nxt = vcp_pkg::PH_ERR;
          end
        end
        vcp_pkg::PH_STAR: begin
          kind_nxt  = vcp_pkg::K_EXACT;
          phase_nxt = vcp_pkg::PH_ERR;
        end
        vcp_pkg::PH_GT: begin
          if (in_char_code == vcp_pkg::CH_EQ) begin
            kind_nxt  = vcp_pkg::K_GTE;
            phase_nxt = vcp_pkg::PH_MAJOR;
          end else begin
            phase_nxt = vcp_pkg::PH_ERR;
          end
        end
        vcp_pkg::PH_MAJOR, vcp_pkg::PH_MINOR, vcp_pkg::PH_PATCH: begin
          if (vcp_pkg::is_digit(in_char_code)) begin
            if (acc_mul > vcp_pkg::NUM_LIMIT) begin
              phase_nxt = vcp_pkg::PH_ERR;
            end else begin
              acc_nxt  = acc_mul[vcp_pkg::NUM_W-1:0];
              seen_nxt = 1'b1;
            end
          end else if (in_char_code == vcp_pkg::CH_DOT && seen_r &&
                       phase_r == vcp_pkg::PH_MAJOR) begin
            major_nxt = acc_r;
            acc_nxt   = '0;
            seen_nxt  = 1'b0;
            phase_nxt = vcp_pkg::PH_MINOR;
          end else if (in_char_code == vcp_pkg::CH_DOT && seen_r &&
                       phase_r == vcp_pkg::PH_MINOR) begin
            minor_nxt = acc_r;
            acc_nxt   = '0;
            seen_nxt  = 1'b0;
            phase_nxt = vcp_pkg::PH_PATCH;
          end else if (in_char_code == vcp_pkg::CH_DASH && seen_r &&
                       phase_r == vcp_pkg::PH_PATCH) begin
            cnt_nxt   = '0;
            phase_nxt = vcp_pkg::PH_PRE;
          end else begin
            phase_nxt = vcp_pkg::PH_ERR;
          end
        end
        vcp_pkg::PH_PRE: begin
          if (cnt_r >= CNT_MAX || !vcp_pkg::is_pre_char(in_char_code)) begin
            phase_nxt = vcp_pkg::PH_ERR;
          end else begin
            ram_we  = 1'b1;
            cnt_nxt = cnt_r + PCW'(1);
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase

      if (in_end_of_text) begin
        ok = (phase_nxt == vcp_pkg::PH_STAR) ||
             (phase_nxt == vcp_pkg::PH_PATCH && seen_nxt) ||
             (phase_nxt == vcp_pkg::PH_PRE && cnt_nxt != '0);
        push.push      = 1'b1;
        push.rec.ok    = ok;
        push.rec.kind  = (phase_nxt == vcp_pkg::PH_WS) ? vcp_pkg::K_EXACT : kind_nxt;
        push.rec.major = (ok && phase_nxt != vcp_pkg::PH_STAR) ? major_nxt : '0;
        push.rec.minor = (ok && phase_nxt != vcp_pkg::PH_STAR) ? minor_nxt : '0;
        push.rec.patch = (ok && phase_nxt != vcp_pkg::PH_STAR) ? acc_nxt : '0;
        push.rec.len   = (ok && phase_nxt == vcp_pkg::PH_PRE) ?
                         vcp_pkg::LEN_W'(cnt_nxt) : '0;
        // end of run: back to the reset state
        phase_nxt = vcp_pkg::PH_WS;
        kind_nxt  = vcp_pkg::K_WILD;
        acc_nxt   = '0;
        seen_nxt  = 1'b0;
        major_nxt = '0;
        minor_nxt = '0;
        cnt_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= vcp_pkg::PH_WS;
      kind_r  <= vcp_pkg::K_WILD;
      acc_r   <= '0;
      seen_r  <= 1'b0;
      major_r <= '0;
      minor_r <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      major_r <= major_nxt;
      minor_r <= minor_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vcp_queue.sv
// ----------------------------------------------------------------------------
// vcp_queue
// Short first-in first-out queue of run summaries between parser and emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module vcp_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vcp_pkg::run_push_t  push,
  input  wire logic                pop,
  output vcp_pkg::run_rec_t        head,
  output logic                     full,
  output logic                     empty
);

  localparam int PW = (vcp_pkg::Q_DEPTH > 1) ? $clog2(vcp_pkg::Q_DEPTH) : 1;
  localparam int CW = $clog2(vcp_pkg::Q_DEPTH + 1);

  vcp_pkg::run_rec_t entry_r [vcp_pkg::Q_DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign full    = (count_r == CW'(vcp_pkg::Q_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push.push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(vcp_pkg::Q_DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(vcp_pkg::Q_DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/vcp_back.sv
// ----------------------------------------------------------------------------
// vcp_back
// Result emitter: sends the run summary, then reads the prerelease characters
// back from the buffer one per cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module vcp_back #(
  parameter int PRE_SIZE = vcp_pkg::PRE_SIZE_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           q_empty,
  input  wire vcp_pkg::run_rec_t              q_head,
  output logic                                q_pop,
  output logic                                ram_re,
  output logic [$clog2(PRE_SIZE)-1:0]         ram_raddr,
  input  wire logic [7:0]                     ram_rdata,
  output logic                                busy,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                out_item_type,
  output logic                                out_valid_res,
  output logic [2:0]                          out_constraint_kind,
  output logic [vcp_pkg::NUM_W-1:0]           out_major_num,
  output logic [vcp_pkg::NUM_W-1:0]           out_minor_num,
  output logic [vcp_pkg::NUM_W-1:0]           out_patch_num,
  output logic [4:0]                          out_pre_length,
  output logic [7:0]                          out_pre_char,
  output logic                                out_final_item
);

  localparam int PCW = $clog2(PRE_SIZE);

  vcp_pkg::bs_t      state_r, state_nxt;
  vcp_pkg::run_rec_t rec_r, rec_nxt;
  logic [PCW-1:0]    idx_r, idx_nxt;
  logic              last_chr;

  assign last_chr = ((vcp_pkg::LEN_W + 1)'(idx_r) + (vcp_pkg::LEN_W + 1)'(1)) ==
                    (vcp_pkg::LEN_W + 1)'(rec_r.len);
  assign busy     = (state_r != vcp_pkg::BS_IDLE);

  assign out_valid           = (state_r == vcp_pkg::BS_SUM) || (state_r == vcp_pkg::BS_CHR);
  assign out_item_type       = (state_r == vcp_pkg::BS_CHR);
  assign out_valid_res       = rec_r.ok;
  assign out_constraint_kind = rec_r.kind;
  assign out_major_num       = rec_r.major;
  assign out_minor_num       = rec_r.minor;
  assign out_patch_num       = rec_r.patch;
  assign out_pre_length      = rec_r.len[4:0];
  assign out_pre_char        = (state_r == vcp_pkg::BS_CHR) ? ram_rdata : 8'd0;
  assign out_final_item      = (state_r == vcp_pkg::BS_CHR) ? last_chr : (rec_r.len == '0);

  always_comb begin
    state_nxt = state_r;
    rec_nxt   = rec_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state_r)
      vcp_pkg::BS_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          rec_nxt   = q_head;
          state_nxt = vcp_pkg::BS_SUM;
        end
      end
      vcp_pkg::BS_SUM: begin
        if (out_ready) begin
          if (rec_r.len == '0) begin
            state_nxt = vcp_pkg::BS_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = '0;
            idx_nxt   = '0;
            state_nxt = vcp_pkg::BS_CHR;
          end
        end
      end
      vcp_pkg::BS_CHR: begin
        if (out_ready) begin
          if (last_chr) begin
            state_nxt = vcp_pkg::BS_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = idx_r + PCW'(1);
            idx_nxt   = idx_r + PCW'(1);
          end
        end
      end
      default: begin
        state_nxt = vcp_pkg::BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    idx_r <= idx_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vcp_pkg::BS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/version_constraint_parser.sv
// ----------------------------------------------------------------------------
// version_constraint_parser
// Parses a version constraint string (operator, major.minor.patch and an
// optional prerelease) into one summary transaction and the prerelease
// characters.
//
//   channel  dir  handshake                fields
//   in_      in   in_valid / in_ready      char_code, end_of_text
//   out_     out  out_valid / out_ready    item_type, valid_res, constraint_kind,
//                                          major/minor/patch_num, pre_length,
//                                          pre_char, final_item
//
// one character is taken per cycle while the input is not stalled; the
// end-of-text character pushes a summary into a two-entry queue.
// the emitter loads a summary from the queue into its register, then sends the
// summary and one prerelease character per cycle while out_ready is high.
// input stalls while the queue is full, and on any character after a prerelease
// dash while an earlier run is still queued or being sent.
// synchronous active-low reset; no clearing pass, the buffer is only read
// where the same run wrote it.
// ----------------------------------------------------------------------------
`default_nettype none

module version_constraint_parser #(
  parameter int PRE_SIZE = vcp_pkg::PRE_SIZE_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_char_code,
  input  wire logic                  in_end_of_text,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_item_type,
  output logic                       out_valid_res,
  output logic [2:0]                 out_constraint_kind,
  output logic [29:0]                out_major_num,
  output logic [29:0]                out_minor_num,
  output logic [29:0]                out_patch_num,
  output logic [4:0]                 out_pre_length,
  output logic [7:0]                 out_pre_char,
  output logic                       out_final_item
);

  localparam int PCW = $clog2(PRE_SIZE);

  vcp_pkg::run_push_t push;
  vcp_pkg::run_rec_t  q_head;
  logic               q_pop, q_full, q_empty;
  logic               ram_we, ram_re, back_busy, ram_busy;
  logic [PCW-1:0]     ram_waddr, ram_raddr;
  logic [7:0]         ram_wdata, ram_rdata;

  assign ram_busy = !q_empty || back_busy;

  vcp_front #(.PRE_SIZE(PRE_SIZE)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char_code   (in_char_code),
    .in_end_of_text (in_end_of_text),
    .q_full         (q_full),
    .ram_busy       (ram_busy),
    .push           (push),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata)
  );

  vcp_ram #(.WIDTH(8), .DEPTH(PRE_SIZE)) u_pre_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  vcp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (q_pop),
    .head  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  vcp_back #(.PRE_SIZE(PRE_SIZE)) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_head              (q_head),
    .q_pop               (q_pop),
    .ram_re              (ram_re),
    .ram_raddr           (ram_raddr),
    .ram_rdata           (ram_rdata),
    .busy                (back_busy),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_item_type       (out_item_type),
    .out_valid_res       (out_valid_res),
    .out_constraint_kind (out_constraint_kind),
    .out_major_num       (out_major_num),
    .out_minor_num       (out_minor_num),
    .out_patch_num       (out_patch_num),
    .out_pre_length      (out_pre_length),
    .out_pre_char        (out_pre_char),
    .out_final_item      (out_final_item)
  );

endmodule

`default_nettype wire

FILE: rtl/core/vcp_checker.sv
// ----------------------------------------------------------------------------
// vcp_checker
// Port-level checks on the result stream of the version constraint parser.
// ----------------------------------------------------------------------------
`default_nettype none

module vcp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_item_type,
  input wire logic        out_valid_res,
  input wire logic [2:0]  out_constraint_kind,
  input wire logic [29:0] out_major_num,
  input wire logic [29:0] out_minor_num,
  input wire logic [29:0] out_patch_num,
  input wire logic [4:0]  out_pre_length,
  input wire logic [7:0]  out_pre_char,
  input wire logic        out_final_item
);

  // stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_item_type) &&
    $stable(out_pre_char) && $stable(out_final_item) && $stable(out_patch_num) &&
    $stable(out_constraint_kind))
    else $error("result changed while stalled");

  // failed parse reports zeros and ends the run
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_item_type && !out_valid_res |->
    out_major_num == 30'd0 && out_minor_num == 30'd0 && out_patch_num == 30'd0 &&
    out_pre_length == 5'd0 && out_final_item)
    else $error("failed parse not reported as zeros");

  // prerelease characters only follow a good parse and are legal characters
  a_pre_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_type |-> out_valid_res &&
    ((out_pre_char >= 8'h30 && out_pre_char <= 8'h39) ||
     (out_pre_char >= 8'h41 && out_pre_char <= 8'h5a) ||
     (out_pre_char >= 8'h61 && out_pre_char <= 8'h7a) ||
     out_pre_char == 8'h2e || out_pre_char == 8'h2d))
    else $error("bad prerelease transaction");

  // a run that is not finished continues with a prerelease character next cycle
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_final_item |=> out_valid && out_item_type)
    else $error("prerelease burst broken");

endmodule

bind version_constraint_parser vcp_checker u_vcp_checker (.*);

`default_nettype wire

FILE: verif/tb_version_constraint_parser.sv
// ----------------------------------------------------------------------------
// tb_version_constraint_parser
// Self-checking bench for the version constraint parser. Constraint strings
// are streamed one character per transaction; a scoreboard class tracks the
// parse of every accepted character and checks each summary and prerelease
// result in order. Directed strings come first, then random ones, mostly
// well-formed with random content. Both sides idle at random except in the last
// phase, and there is one long receiver stall and a full drain between phases.
// ----------------------------------------------------------------------------

typedef struct packed {
  bit        item_type;
  bit        valid_res;
  bit [2:0]  kind;
  bit [29:0] major_num;
  bit [29:0] minor_num;
  bit [29:0] patch_num;
  bit [4:0]  pre_length;
  bit [7:0]  pre_char;
  bit        final_item;
} parse_result_t;

localparam int PRE_MAX = vcp_pkg::PRE_SIZE_DEF - 1;

class vcp_scoreboard;
  vcp_pkg::ph_t   phase;
  vcp_pkg::kind_t kind;
  bit [29:0]      acc;
  bit             seen;
  bit [29:0]      major;
  bit [29:0]      minor;
  bit [7:0]       pre_buf [vcp_pkg::PRE_SIZE_DEF];
  int unsigned    pre_cnt;
  bit             err;
  parse_result_t  result_q[$];
  int             mismatches;

  function new();
    mismatches = 0;
    clear_run();
  endfunction

  function void clear_run();
    phase   = vcp_pkg::PH_WS;
    kind    = vcp_pkg::K_WILD;
    acc     = '0;
    seen    = 1'b0;
    major   = '0;
    minor   = '0;
    pre_cnt = 0;
    err     = 1'b0;
  endfunction

  function void fail_run();
    err   = 1'b1;
    phase = vcp_pkg::PH_ERR;
  endfunction

  function void number_step(bit [7:0] c);
    longint unsigned v;
    if (c >= vcp_pkg::CH_ZERO && c <= "9") begin
      v = longint'(acc) * 10 + longint'(c - vcp_pkg::CH_ZERO);
      if (v > vcp_pkg::NUM_LIMIT) begin
        fail_run();
        return;
      end
      acc  = v[29:0];
      seen = 1'b1;
    end else if (c == vcp_pkg::CH_DOT && seen && phase == vcp_pkg::PH_MAJOR) begin
      major = acc;
      acc   = '0;
      seen  = 1'b0;
      phase = vcp_pkg::PH_MINOR;
    end else if (c == vcp_pkg::CH_DOT && seen && phase == vcp_pkg::PH_MINOR) begin
      minor = acc;
      acc   = '0;
      seen  = 1'b0;
      phase = vcp_pkg::PH_PATCH;
    end else if (c == vcp_pkg::CH_DASH && seen && phase == vcp_pkg::PH_PATCH) begin
      pre_cnt = 0;
      phase   = vcp_pkg::PH_PRE;
    end else begin
      fail_run();
    end
  endfunction

  function void note_char(bit [7:0] c, bit eot);
    parse_result_t r;
    bit            ok;
    bit            pre_valid;
    pre_valid = (c >= vcp_pkg::CH_ZERO && c <= "9") || (c >= "a" && c <= "z") ||
                (c >= "A" && c <= "Z") || c == vcp_pkg::CH_DOT || c == vcp_pkg::CH_DASH;
    case (phase)
      vcp_pkg::PH_WS: begin
        if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
        end else if (c == vcp_pkg::CH_STAR) begin
          kind  = vcp_pkg::K_WILD;
          phase = vcp_pkg::PH_STAR;
        end else if (c == vcp_pkg::CH_CARET) begin
          kind  = vcp_pkg::K_CARET;
          phase = vcp_pkg::PH_MAJOR;
        end else if (c == vcp_pkg::CH_TILDE) begin
          kind  = vcp_pkg::K_TILDE;
          phase = vcp_pkg::PH_MAJOR;
        end else if (c == vcp_pkg::CH_GT) begin
          kind  = vcp_pkg::K_EXACT;
          phase = vcp_pkg::PH_GT;
        end else if (c == vcp_pkg::CH_LT) begin
          kind  = vcp_pkg::K_LT;
          phase = vcp_pkg::PH_MAJOR;
        end else begin
          kind  = vcp_pkg::K_EXACT;
          phase = vcp_pkg::PH_MAJOR;
          number_step(c);
        end
      end
      vcp_pkg::PH_STAR: begin
        kind = vcp_pkg::K_EXACT;
        fail_run();
      end
      vcp_pkg::PH_GT: begin
        if (c == vcp_pkg::CH_EQ) begin
          kind  = vcp_pkg::K_GTE;
          phase = vcp_pkg::PH_MAJOR;
        end else begin
          fail_run();
        end
      end
      vcp_pkg::PH_MAJOR, vcp_pkg::PH_MINOR, vcp_pkg::PH_PATCH: number_step(c);
      vcp_pkg::PH_PRE: begin
        if (pre_cnt >= PRE_MAX || !pre_valid) begin
          fail_run();
        end else begin
          pre_buf[pre_cnt] = c;
          pre_cnt++;
        end
      end
      default: ;
    endcase

    if (!eot) return;

    ok = !err && (phase == vcp_pkg::PH_STAR || (phase == vcp_pkg::PH_PATCH && seen) ||
                  (phase == vcp_pkg::PH_PRE && pre_cnt > 0));
    r.item_type  = 1'b0;
    r.valid_res  = ok;
    r.kind       = (phase == vcp_pkg::PH_WS) ? vcp_pkg::K_EXACT : kind;
    r.major_num  = (ok && phase != vcp_pkg::PH_STAR) ? major : '0;
    r.minor_num  = (ok && phase != vcp_pkg::PH_STAR) ? minor : '0;
    r.patch_num  = (ok && phase != vcp_pkg::PH_STAR) ? acc : '0;
    r.pre_length = (ok && phase == vcp_pkg::PH_PRE) ? pre_cnt[4:0] : '0;
    r.pre_char   = '0;
    r.final_item = (r.pre_length == 0);
    result_q.push_back(r);
    for (int i = 0; i < r.pre_length; i++) begin
      r.item_type  = 1'b1;
      r.pre_char   = pre_buf[i];
      r.final_item = (i + 1 == r.pre_length);
      result_q.push_back(r);
    end
    clear_run();
  endfunction

  function void check_result(parse_result_t got);
    parse_result_t want;
    if (result_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result: type=%0d ok=%0d kind=%0d %0d.%0d.%0d len=%0d chr=%02h",
                 got.item_type, got.valid_res, got.kind, got.major_num, got.minor_num,
                 got.patch_num, got.pre_length, got.pre_char);
      return;
    end
    want = result_q.pop_front();
    if (got != want) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch at %0t", $realtime);
        $display("  expected type=%0d ok=%0d kind=%0d %0d.%0d.%0d len=%0d chr=%02h fin=%0d",
                 want.item_type, want.valid_res, want.kind, want.major_num,
                 want.minor_num, want.patch_num, want.pre_length, want.pre_char,
                 want.final_item);
        $display("  actual   type=%0d ok=%0d kind=%0d %0d.%0d.%0d len=%0d chr=%02h fin=%0d",
                 got.item_type, got.valid_res, got.kind, got.major_num,
                 got.minor_num, got.patch_num, got.pre_length, got.pre_char,
                 got.final_item);
      end
    end
  endfunction
endclass

module tb_version_constraint_parser;

  localparam int LONG_HOLD  = 300;
  localparam int RAND_CHARS = 120;
  localparam int SETTLE     = 10;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_code   = 8'h20;
  logic        in_end_of_text = 1'b0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic        out_item_type;
  logic        out_valid_res;
  logic [2:0]  out_constraint_kind;
  logic [29:0] out_major_num;
  logic [29:0] out_minor_num;
  logic [29:0] out_patch_num;
  logic [4:0]  out_pre_length;
  logic [7:0]  out_pre_char;
  logic        out_final_item;

  int unsigned   send_idle = 25;
  int unsigned   recv_idle = 45;
  bit            hold_req  = 1'b0;
  int unsigned   rand_sent = 0;
  bit [7:0]      text_q[$];
  vcp_scoreboard sb = new();

  version_constraint_parser dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_char_code        (in_char_code),
    .in_end_of_text      (in_end_of_text),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_item_type       (out_item_type),
    .out_valid_res       (out_valid_res),
    .out_constraint_kind (out_constraint_kind),
    .out_major_num       (out_major_num),
    .out_minor_num       (out_minor_num),
    .out_patch_num       (out_patch_num),
    .out_pre_length      (out_pre_length),
    .out_pre_char        (out_pre_char),
    .out_final_item      (out_final_item)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // receiver: random back-pressure, or a long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  always @(posedge clk) begin : monitor
    parse_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_char(in_char_code, in_end_of_text);
      if (out_valid && out_ready) begin
        got = '{out_item_type, out_valid_res, out_constraint_kind, out_major_num,
                out_minor_num, out_patch_num, out_pre_length, out_pre_char,
                out_final_item};
        sb.check_result(got);
      end
    end
  end

  task automatic send_char(bit [7:0] c, bit eot);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_char_code   <= c;
    in_end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.result_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic void add_blank();
    int unsigned r;
    r = $urandom_range(5);
    text_q.push_back((r == 5) ? 8'd32 : 8'd9 + r[7:0]);
  endfunction

  function automatic void add_rand_number();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45)      add_str($sformatf("%0d", $urandom_range(9)));
    else if (r < 70) add_str($sformatf("%0d", $urandom_range(99999)));
    else if (r < 82) add_str($sformatf("%0d", $urandom_range(999999999, 999999000)));
    else if (r < 88) add_str($sformatf("0%0d", $urandom_range(99)));
    else if (r < 95) add_str($sformatf("%0d", $urandom_range(32'hffffffff, 1000000000)));
  endfunction

  function automatic void add_prerelease(int unsigned len);
    bit [7:0] c;
    text_q.push_back(vcp_pkg::CH_DASH);
    repeat (len) begin
      case ($urandom_range(4))
        0:       c = vcp_pkg::CH_ZERO + 8'($urandom_range(9));
        1:       c = 8'("a") + 8'($urandom_range(25));
        2:       c = 8'("A") + 8'($urandom_range(25));
        3:       c = vcp_pkg::CH_DOT;
        default: c = vcp_pkg::CH_DASH;
      endcase
      text_q.push_back(c);
    end
  endfunction

  function automatic void build_random_text();
    int unsigned r;
    int unsigned pos;
    r = $urandom_range(99);
    repeat ($urandom_range(2)) add_blank();
    if (r < 4) begin
      add_blank();
    end else if (r < 9) begin
      repeat ($urandom_range(6, 1)) text_q.push_back(8'($urandom_range(255, 1)));
    end else if (r < 15) begin
      text_q.push_back(vcp_pkg::CH_STAR);
      if ($urandom_range(3) == 0) add_str("1");
    end else begin
      case ($urandom_range(6))
        1: text_q.push_back(vcp_pkg::CH_CARET);
        2: text_q.push_back(vcp_pkg::CH_TILDE);
        3: begin
          text_q.push_back(vcp_pkg::CH_GT);
          text_q.push_back(vcp_pkg::CH_EQ);
        end
        4: text_q.push_back(vcp_pkg::CH_LT);
        5: text_q.push_back(vcp_pkg::CH_GT);
        default: ;
      endcase
      add_rand_number();
      if ($urandom_range(19) != 0) begin
        text_q.push_back(vcp_pkg::CH_DOT);
        add_rand_number();
      end
      if ($urandom_range(19) != 0) begin
        text_q.push_back(vcp_pkg::CH_DOT);
        add_rand_number();
      end
      if ($urandom_range(99) < 40) begin
        r = $urandom_range(99);
        add_prerelease(r < 85 ? $urandom_range(8, 1) :
                       r < 92 ? PRE_MAX : r < 96 ? PRE_MAX + 1 : 0);
      end
    end
    if (text_q.size() == 0) add_blank();
    r = $urandom_range(99);
    if (r < 10) begin
      pos = $urandom_range(text_q.size() - 1);
      text_q[pos] = 8'($urandom_range(255, 1));
    end else if (r < 14) begin
      add_blank();
    end
  endfunction

  task automatic send_random_text();
    build_random_text();
    rand_sent += text_q.size();
    send_text();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed strings
    add_str("*");                          send_text();
    add_str("*1");                         send_text();
    for (int c = 9; c <= 13; c++) text_q.push_back(8'(c));
    add_str(" 7.8.9");                     send_text();
    add_str(">=999999999.999999999.999999999"); send_text();
    add_str("<0.0.0");                     send_text();
    add_str("~1.2.3-aZ9.-");               send_text();
    add_str("^4.5.6");                     send_text();
    add_str(">5.0.0");                     send_text();
    add_str("1.2.3 ");                     send_text();
    add_str("1.2.3-");                     send_text();
    add_str("1000000000.1.1");             send_text();
    add_str("1..2");                       send_text();
    add_str("2.3.4-a_b");                  send_text();
    text_q.push_back(8'hff);               send_text();
    add_str(" ");                          send_text();
    add_str("0.0.1");
    add_prerelease(PRE_MAX);               send_text();
    drain();

    // idle mix 1, with a long receiver hold-off while the sender keeps going
    hold_req  = 1'b1;
    rand_sent = 0;
    while (rand_sent < RAND_CHARS / 3 || hold_req) send_random_text();
    drain();

    send_idle = 45;
    recv_idle = 25;
    rand_sent = 0;
    while (rand_sent < RAND_CHARS / 3) send_random_text();
    drain();

    send_idle = 0;
    recv_idle = 0;
    rand_sent = 0;
    while (rand_sent < RAND_CHARS / 3) send_random_text();
    drain();

    if (sb.mismatches == 0 && sb.result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
